FILE: rtl/core/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// shared types and constants of the quaternion vector rotation pipeline
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int unsigned LANES = 3;

  typedef struct packed {
    logic valid;
    logic last;
    logic zero;
  } ctl_t;

endpackage

FILE: rtl/core/qvr_matrix.sv
// ----------------------------------------------------------------------------
// qvr_matrix
// two stages: pairwise quaternion products, then squared norm and the
// nine entries of the unnormalized rotation matrix
// ----------------------------------------------------------------------------
module qvr_matrix #(
  parameter int unsigned W = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  qvr_pkg::ctl_t          in_ctl,
  input  logic signed [W-1:0]    qx,
  input  logic signed [W-1:0]    qy,
  input  logic signed [W-1:0]    qz,
  input  logic signed [W-1:0]    qw,
  input  logic signed [W-1:0]    in_v [qvr_pkg::LANES],
  output qvr_pkg::ctl_t          out_ctl,
  output logic signed [2*W:0]    m [9],
  output logic [2*W:0]           s,
  output logic signed [W-1:0]    out_v [qvr_pkg::LANES]
);
  import qvr_pkg::*;

  logic signed [2*W-1:0] xx, xy, xz, xw, yy, yz, yw, zz, zw, ww;
  logic signed [W-1:0]   v1 [LANES];
  ctl_t                  ctl1;
  logic signed [2*W:0]   m_next [9];
  logic [2*W:0]          s_next;

  function automatic logic signed [2*W:0] sx(input logic signed [2*W-1:0] a);
    return signed'({a[2*W-1], a});
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else if (en) begin
      ctl1 <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx <= qx * qx;
      xy <= qx * qy;
      xz <= qx * qz;
      xw <= qx * qw;
      yy <= qy * qy;
      yz <= qy * qz;
      yw <= qy * qw;
      zz <= qz * qz;
      zw <= qz * qw;
      ww <= qw * qw;
      v1 <= in_v;
    end
  end

  always_comb begin
    s_next = {1'b0, xx} + {1'b0, yy} + {1'b0, zz} + {1'b0, ww};
    m_next[0] = -(sx(yy) + sx(zz));
    m_next[1] = sx(xy) - sx(zw);
    m_next[2] = sx(yw) + sx(xz);
    m_next[3] = sx(zw) + sx(xy);
    m_next[4] = -(sx(xx) + sx(zz));
    m_next[5] = sx(yz) - sx(xw);
    m_next[6] = sx(xz) - sx(yw);
    m_next[7] = sx(xw) + sx(yz);
    m_next[8] = -(sx(xx) + sx(yy));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (en) begin
      out_ctl <= '{valid: ctl1.valid, last: ctl1.last, zero: (s_next == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m     <= m_next;
      s     <= s_next;
      out_v <= v1;
    end
  end

endmodule

FILE: rtl/core/qvr_dot.sv
// ----------------------------------------------------------------------------
// qvr_dot
// four stages: split matrix-vector partial products, term assembly,
// row sums, then magnitude and rounding numerator and denominator
// ----------------------------------------------------------------------------
module qvr_dot #(
  parameter int unsigned W = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  qvr_pkg::ctl_t          in_ctl,
  input  logic signed [2*W:0]    m [9],
  input  logic [2*W:0]           s,
  input  logic signed [W-1:0]    in_v [qvr_pkg::LANES],
  output qvr_pkg::ctl_t          out_ctl,
  output logic [3*W+2:0]         num [qvr_pkg::LANES],
  output logic [2*W+1:0]         den,
  output logic                   neg [qvr_pkg::LANES],
  output logic signed [W-1:0]    out_v [qvr_pkg::LANES]
);
  import qvr_pkg::*;

  logic signed [2*W:0] lo3 [9];
  logic signed [2*W:0] hi3 [9];
  logic signed [3*W:0] term4 [9];
  logic signed [3*W:0] dot5 [LANES];
  logic [2*W:0]        s3, s4, s5;
  logic signed [W-1:0] v3 [LANES];
  logic signed [W-1:0] v4 [LANES];
  logic signed [W-1:0] v5 [LANES];
  ctl_t                ctl3, ctl4, ctl5;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3    <= '0;
      ctl4    <= '0;
      ctl5    <= '0;
      out_ctl <= '0;
    end else if (en) begin
      ctl3    <= in_ctl;
      ctl4    <= ctl3;
      ctl5    <= ctl4;
      out_ctl <= ctl5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        lo3[k] <= signed'({1'b0, m[k][W-1:0]}) * in_v[k % 3];
        hi3[k] <= signed'(m[k][2*W:W]) * in_v[k % 3];
      end
      for (int k = 0; k < 9; k++) begin
        term4[k] <= (signed'({{W{hi3[k][2*W]}}, hi3[k]}) <<< W)
                  + signed'({{W{lo3[k][2*W]}}, lo3[k]});
      end
      for (int r = 0; r < 3; r++) begin
        dot5[r] <= term4[3*r] + term4[3*r+1] + term4[3*r+2];
      end
      for (int r = 0; r < 3; r++) begin
        neg[r] <= dot5[r][3*W];
        num[r] <= {(dot5[r][3*W] ? -dot5[r] : dot5[r]), 2'b00}
                + {{(W+2){1'b0}}, s5};
      end
      den   <= {s5, 1'b0};
      s3    <= s;
      s4    <= s3;
      s5    <= s4;
      v3    <= in_v;
      v4    <= v3;
      v5    <= v4;
      out_v <= v5;
    end
  end

endmodule

FILE: rtl/core/qvr_div.sv
// ----------------------------------------------------------------------------
// qvr_div
// pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one denominator
// ----------------------------------------------------------------------------
module qvr_div #(
  parameter int unsigned W  = 32,
  parameter int unsigned QW = W + 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  qvr_pkg::ctl_t          in_ctl,
  input  logic [3*W+2:0]         num [qvr_pkg::LANES],
  input  logic [2*W+1:0]         den,
  input  logic                   in_neg [qvr_pkg::LANES],
  input  logic signed [W-1:0]    in_v [qvr_pkg::LANES],
  output qvr_pkg::ctl_t          out_ctl,
  output logic [QW-1:0]          quot [qvr_pkg::LANES],
  output logic                   out_neg [qvr_pkg::LANES],
  output logic signed [W-1:0]    out_v [qvr_pkg::LANES]
);
  import qvr_pkg::*;

  localparam int unsigned RW = 2 * W + 2;
  localparam int unsigned NW = 3 * W + 3;

  logic [RW-1:0]       rem_r  [QW][LANES];
  logic [QW-1:0]       q_r    [QW][LANES];
  logic [QW-1:0]       rest_r [QW][LANES];
  logic                neg_r  [QW][LANES];
  logic signed [W-1:0] v_r    [QW][LANES];
  logic [RW-1:0]       den_r  [QW];
  ctl_t                ctl_r  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0] den_p;
    ctl_t          ctl_p;

    if (k == 0) begin : g_first
      assign den_p = den;
      assign ctl_p = in_ctl;
    end else begin : g_next
      assign den_p = den_r[k-1];
      assign ctl_p = ctl_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_r[k] <= '0;
      end else if (en) begin
        ctl_r[k] <= ctl_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_p;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RW-1:0]       rem_p;
      logic [QW-1:0]       q_p;
      logic [QW-1:0]       rest_p;
      logic                neg_p;
      logic signed [W-1:0] v_p;
      logic [RW:0]         t;
      logic                ge;

      if (k == 0) begin : g_first
        assign rem_p  = {1'b0, num[l][NW-1:QW]};
        assign q_p    = '0;
        assign rest_p = num[l][QW-1:0];
        assign neg_p  = in_neg[l];
        assign v_p    = in_v[l];
      end else begin : g_next
        assign rem_p  = rem_r[k-1][l];
        assign q_p    = q_r[k-1][l];
        assign rest_p = rest_r[k-1][l];
        assign neg_p  = neg_r[k-1][l];
        assign v_p    = v_r[k-1][l];
      end

      assign t  = {rem_p, rest_p[QW-1]};
      assign ge = (t >= {1'b0, den_p});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l]  <= ge ? RW'(t - {1'b0, den_p}) : t[RW-1:0];
          q_r[k][l]    <= {q_p[QW-2:0], ge};
          rest_r[k][l] <= {rest_p[QW-2:0], 1'b0};
          neg_r[k][l]  <= neg_p;
          v_r[k][l]    <= v_p;
        end
      end
    end
  end

  assign out_ctl = ctl_r[QW-1];
  assign quot    = q_r[QW-1];
  assign out_neg = neg_r[QW-1];
  assign out_v   = v_r[QW-1];

endmodule

FILE: rtl/core/qvr_out.sv
// ----------------------------------------------------------------------------
// qvr_out
// output stage: signed correction added to the vector, saturation and
// zero-quaternion override, registered result item
// ----------------------------------------------------------------------------
module qvr_out #(
  parameter int unsigned W  = 32,
  parameter int unsigned QW = W + 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  qvr_pkg::ctl_t          in_ctl,
  input  logic [QW-1:0]          quot [qvr_pkg::LANES],
  input  logic                   neg [qvr_pkg::LANES],
  input  logic signed [W-1:0]    in_v [qvr_pkg::LANES],
  output logic                   valid,
  output logic signed [W-1:0]    rot [qvr_pkg::LANES],
  output logic                   zero_quat,
  output logic                   saturated,
  output logic                   last
);
  import qvr_pkg::*;

  localparam logic signed [W+2:0] MAXV = signed'({4'b0000, {(W-1){1'b1}}});
  localparam logic signed [W+2:0] MINV = ~MAXV;

  logic signed [W+2:0] sum  [LANES];
  logic signed [W+2:0] dq   [LANES];
  logic signed [W-1:0] rot_next [LANES];
  logic [LANES-1:0]    clip;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      dq[l]  = signed'({1'b0, quot[l]});
      sum[l] = signed'({{3{in_v[l][W-1]}}, in_v[l]}) + (neg[l] ? -dq[l] : dq[l]);
      clip[l] = 1'b0;
      if (in_ctl.zero) begin
        rot_next[l] = '0;
      end else if (sum[l] > MAXV) begin
        rot_next[l] = MAXV[W-1:0];
        clip[l]     = 1'b1;
      end else if (sum[l] < MINV) begin
        rot_next[l] = MINV[W-1:0];
        clip[l]     = 1'b1;
      end else begin
        rot_next[l] = sum[l][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot       <= rot_next;
      zero_quat <= in_ctl.zero;
      saturated <= |clip;
      last      <= in_ctl.last;
    end
  end

endmodule

FILE: rtl/core/quaternion_vector_rotate.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// rotates one signed fixed-point 3-vector by one quaternion per item
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries quat_x..quat_w, vec_x..vec_z and
//   in_last; output channel out_valid/out_ready carries rot_x..rot_z,
//   zero_quat, saturated and out_last, one result item per input item.
//   the quaternion need not be of unit length; the result is rounded to
//   nearest (ties away from zero) and saturated to the field range.
//   the pipeline holds two stages of quaternion products, four of
//   matrix-vector arithmetic, one per quotient bit in the rounding divider
//   and the output register. throughput is one item per cycle; the whole
//   pipeline advances as one and holds when the output item is not taken,
//   so in_ready is low only while out_valid is high and out_ready is low.
//   reset clears all stage valid bits; no item is in flight afterward.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] quat_x,
  input  logic signed [DATA_WIDTH-1:0] quat_y,
  input  logic signed [DATA_WIDTH-1:0] quat_z,
  input  logic signed [DATA_WIDTH-1:0] quat_w,
  input  logic signed [DATA_WIDTH-1:0] vec_x,
  input  logic signed [DATA_WIDTH-1:0] vec_y,
  input  logic signed [DATA_WIDTH-1:0] vec_z,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] rot_x,
  output logic signed [DATA_WIDTH-1:0] rot_y,
  output logic signed [DATA_WIDTH-1:0] rot_z,
  output logic                         zero_quat,
  output logic                         saturated,
  output logic                         out_last
);
  import qvr_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned QW = W + 2;

  logic                en;
  ctl_t                in_ctl, mat_ctl, dot_ctl, div_ctl;
  logic signed [W-1:0] vin   [LANES];
  logic signed [W-1:0] mat_v [LANES];
  logic signed [W-1:0] dot_v [LANES];
  logic signed [W-1:0] div_v [LANES];
  logic signed [2*W:0] m [9];
  logic [2*W:0]        s;
  logic [3*W+2:0]      num [LANES];
  logic [2*W+1:0]      den;
  logic                dot_neg [LANES];
  logic                div_neg [LANES];
  logic [QW-1:0]       quot [LANES];
  logic signed [W-1:0] rot [LANES];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign in_ctl   = '{valid: in_valid, last: in_last, zero: 1'b0};
  assign vin[0]   = vec_x;
  assign vin[1]   = vec_y;
  assign vin[2]   = vec_z;

  qvr_matrix #(.W(W)) u_matrix (
    .clk(clk), .rst(rst), .en(en), .in_ctl(in_ctl),
    .qx(quat_x), .qy(quat_y), .qz(quat_z), .qw(quat_w), .in_v(vin),
    .out_ctl(mat_ctl), .m(m), .s(s), .out_v(mat_v)
  );

  qvr_dot #(.W(W)) u_dot (
    .clk(clk), .rst(rst), .en(en), .in_ctl(mat_ctl),
    .m(m), .s(s), .in_v(mat_v),
    .out_ctl(dot_ctl), .num(num), .den(den), .neg(dot_neg), .out_v(dot_v)
  );

  qvr_div #(.W(W), .QW(QW)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_ctl(dot_ctl),
    .num(num), .den(den), .in_neg(dot_neg), .in_v(dot_v),
    .out_ctl(div_ctl), .quot(quot), .out_neg(div_neg), .out_v(div_v)
  );

  qvr_out #(.W(W), .QW(QW)) u_out (
    .clk(clk), .rst(rst), .en(en), .in_ctl(div_ctl),
    .quot(quot), .neg(div_neg), .in_v(div_v),
    .valid(out_valid), .rot(rot), .zero_quat(zero_quat),
    .saturated(saturated), .last(out_last)
  );

  assign rot_x = rot[0];
  assign rot_y = rot[1];
  assign rot_z = rot[2];

`ifndef SYNTHESIS
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_quat |-> rot_x == '0 && rot_y == '0 && rot_z == '0)
    else $error("zero quaternion item with nonzero result");

  a_zero_no_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_quat |-> !saturated)
    else $error("zero quaternion item flagged as saturated");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      rot_x == {1'b0, {(W-1){1'b1}}} || rot_x == {1'b1, {(W-1){1'b0}}} ||
      rot_y == {1'b0, {(W-1){1'b1}}} || rot_y == {1'b1, {(W-1){1'b0}}} ||
      rot_z == {1'b0, {(W-1){1'b1}}} || rot_z == {1'b1, {(W-1){1'b0}}})
    else $error("saturated item with no component at a limit");
`endif

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks quaternion_vector_rotate against a wide-integer prediction of the
// rotated vector; random bursts on the input, random stalls on the output
// ----------------------------------------------------------------------------
class rotation_scoreboard;
  typedef struct {
    logic signed [31:0] x, y, z;
    logic zero, sat, last;
  } rot_item_t;

  rot_item_t pending[$];
  int mismatches = 0;

  function automatic logic signed [31:0] rot_component(logic signed [31:0] v,
                                                       logic signed [255:0] dot,
                                                       logic signed [255:0] s,
                                                       ref logic clip);
    logic signed [255:0] mag, num, quot, sum;
    logic neg;
    neg = dot < 0;
    mag = neg ? -dot : dot;
    num = 4 * mag + s;
    quot = num / (2 * s);
    sum = v + (neg ? -quot : quot);
    if (sum > 256'sd2147483647) begin
      sum = 256'sd2147483647;
      clip = 1;
    end
    if (sum < -256'sd2147483648) begin
      sum = -256'sd2147483648;
      clip = 1;
    end
    return sum[31:0];
  endfunction

  function void note_input(logic signed [31:0] qx, qy, qz, qw, vx, vy, vz,
                           logic last);
    logic signed [255:0] x, y, z, w, a, b, c, s, d0, d1, d2;
    logic signed [255:0] xx, xy, xz, xw, yy, yz, yw, zz, zw, ww;
    rot_item_t r;
    logic clip;
    x = qx; y = qy; z = qz; w = qw; a = vx; b = vy; c = vz;
    xx = x*x; xy = x*y; xz = x*z; xw = x*w; yy = y*y;
    yz = y*z; yw = y*w; zz = z*z; zw = z*w; ww = w*w;
    s = xx + yy + zz + ww;
    r.last = last;
    clip = 0;
    if (s == 0) begin
      r.x = 0; r.y = 0; r.z = 0; r.zero = 1; r.sat = 0;
    end else begin
      d0 = -(yy+zz)*a + (xy-zw)*b + (yw+xz)*c;
      d1 = (zw+xy)*a - (xx+zz)*b + (yz-xw)*c;
      d2 = (xz-yw)*a + (xw+yz)*b - (xx+yy)*c;
      r.x = rot_component(vx, d0, s, clip);
      r.y = rot_component(vy, d1, s, clip);
      r.z = rot_component(vz, d2, s, clip);
      r.zero = 0;
      r.sat = clip;
    end
    pending.push_back(r);
  endfunction

  function void check_result(logic signed [31:0] x, y, z, logic zero, sat, last);
    rot_item_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item %h %h %h", x, y, z);
      return;
    end
    e = pending.pop_front();
    if (e.x !== x || e.y !== y || e.z !== z || e.zero !== zero || e.sat !== sat
        || e.last !== last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("exp %h %h %h z%b s%b l%b got %h %h %h z%b s%b l%b",
                 e.x, e.y, e.z, e.zero, e.sat, e.last, x, y, z, zero, sat, last);
    end
  endfunction
endclass

module tb;
  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic signed [31:0] quat_x = 0, quat_y = 0, quat_z = 0, quat_w = 0;
  logic signed [31:0] vec_x = 0, vec_y = 0, vec_z = 0;
  logic in_last = 0;
  logic signed [31:0] rot_x, rot_y, rot_z;
  logic zero_quat, saturated, out_last;
  rotation_scoreboard board = new();
  int cycle_count = 0;
  int hold_off = 0;
  bit stimulus_done = 0;

  always #2 clk = ~clk;

  quaternion_vector_rotate dut (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // long hold-off counter
  always @(posedge clk) begin
    if (cycle_count == 300) hold_off <= 150;
    else if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // output side: stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result(rot_x, rot_y, rot_z, zero_quat, saturated, out_last);
    if (hold_off > 1 || cycle_count == 300) out_ready <= 0;
    else if (cycle_count % 97 < 30) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 0;
      3: return 32'h4000_0000;
      4: return $urandom_range(0, 7) - 3;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [31:0] qx, qy, qz, qw, vx, vy, vz, logic last);
    in_valid <= 1;
    quat_x <= qx; quat_y <= qy; quat_z <= qz; quat_w <= qw;
    vec_x <= vx; vec_y <= vy; vec_z <= vz; in_last <= last;
    do @(posedge clk); while (!in_ready);
    board.note_input(qx, qy, qz, qw, vx, vy, vz, last);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    int burst;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_item(0, 0, 0, 0, 32'h4000_0000, 1, 2, 1);
    send_item(0, 0, 0, 32'h4000_0000, 32'h7fff_ffff, 32'h8000_0000, 3, 0);
    send_item(32'h4000_0000, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 5, 1);
    send_item(0, 32'h4000_0000, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_item(0, 0, 32'h4000_0000, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1);
    send_item(1, 0, 0, 1, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
    send_item(1, 1, 1, 1, 1, 2, 3, 0);
    send_item(0, 0, 0, 1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1);
    send_item(32'hffff_ffff, 0, 0, 0, 1, 1, 1, 0);
    for (int i = 0; i < 700; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++, i++)
        send_item(pick_value(), pick_value(), pick_value(), pick_value(),
                  pick_value(), pick_value(), pick_value(), $urandom_range(0, 1));
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
